/* hw/rtl/cfp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the checksummed frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

	// Configuration register indexes.
	localparam logic [7:0] CFG_HEADER_FIRST   = 8'd0;
	localparam logic [7:0] CFG_HEADER_SECOND  = 8'd1;
	localparam logic [7:0] CFG_DATA_TYPE_CODE = 8'd2;
	localparam logic [7:0] CFG_LENGTH_LIMIT   = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0] RST_HEADER_FIRST   = 8'd170;
	localparam logic [7:0] RST_HEADER_SECOND  = 8'd85;
	localparam logic [1:0] RST_DATA_TYPE_CODE = 2'd1;
	localparam logic [6:0] RST_LENGTH_LIMIT   = 7'd50;

	// Frame format constants.
	localparam logic [7:0] TYPE_BOUND  = 8'd4;
	localparam logic [6:0] LIMIT_CAP   = 7'd64;
	localparam int         STORE_SLOTS = 8;

	// Result status codes.
	localparam logic [1:0] ST_CSUM_ERR = 2'd0;
	localparam logic [1:0] ST_ACCEPT   = 2'd1;
	localparam logic [1:0] ST_DATA     = 2'd2;

	// Widths of the packed result and of the output user and data buses.
	// Status and frame class travel on the user bus, the rest on the data bus.
	localparam int RESULT_W = 82;
	localparam int M_USER_W = 4;
	localparam int M_DATA_W = 80;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [1:0] data_type_code;
		logic [6:0] length_limit;
	} cfg_t;

	// The last member lands in the lowest bits, so the bus order runs from
	// status upward to steer_output_value.
	typedef struct packed {
		logic [15:0] steer_output_value;
		logic [15:0] target_angle_value;
		logic [15:0] angle_value;
		logic [15:0] speed_value;
		logic [5:0]  payload_length;
		logic [7:0]  identifier;
		logic [1:0]  frame_class;
		logic [1:0]  status;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/checksummed_frame_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_parser
// Byte-stream frame parser with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer on the s_ side and sustains
// one byte per clock cycle. A byte is captured in an input register and then
// goes through the frame state machine, so a completed frame is loaded into
// the output register, which drives m_tvalid, when the parse stage takes the
// checksum byte out of the input register, and m_tvalid is set by that load.
// The output register parts the two sides: bytes keep flowing while a result
// waits, and only a checksum byte that arrives while the earlier result has
// not been taken holds back the input, until m_tready takes that result.
// A frame is two header bytes, a type below 4, an identifier, a nonzero
// length below length_limit (capped at 64), the payload and a checksum that
// is the modulo-256 sum of all earlier bytes. A byte that does not fit sends
// the parser back to idle and is consumed. Each completed frame gives one
// result transfer whose status on m_tuser tells checksum error, accepted
// frame or accepted data frame; only a data frame carries the four 16-bit
// values taken little-endian from payload bytes 0 to 7. The eight-byte
// payload store keeps its contents across frames; after a short payload the
// checksum byte goes to the next slot. The user is to write configuration
// only while idle, not enforced by the block; a write is always taken at once.
// ----------------------------------------------------------------------------
module checksummed_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Received bytes.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Frame results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [3:0]       m_tuser,   // [1:0] status, [3:2] frame_class
	// [7:0] identifier, [13:8] payload_length, [29:14] speed_value,
	// [45:30] angle_value, [61:46] target_angle_value,
	// [77:62] steer_output_value, [79:78] zero
	output logic [79:0]      m_tdata
);
	import cfp_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	logic [7:0] byte_s1;
	logic    advance;
	logic    step;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_res_q;

	// Configuration writes never stall.
	assign cfg_ready = 1'b1;

	cfp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The output register is free when it is empty or being emptied in this
	// cycle. The parse stage runs whenever it is free or the waiting byte
	// does not complete a frame.
	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && (advance || !res_valid);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	cfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: loaded when a frame completes, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_res_q[M_USER_W-1:0];
	assign m_tdata  = {{(M_DATA_W - RESULT_W + M_USER_W){1'b0}},
		out_res_q[RESULT_W-1:M_USER_W]};

endmodule
`default_nettype wire

/* hw/rtl/cfp_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module cfp_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [7:0]    wr_index,
	input  wire logic [7:0]    wr_data,
	output cfp_pkg::cfg_t      cfg
);
	import cfp_pkg::*;

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// Writes to indexes past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first   <= RST_HEADER_FIRST;
			cfg_q.header_second  <= RST_HEADER_SECOND;
			cfg_q.data_type_code <= RST_DATA_TYPE_CODE;
			cfg_q.length_limit   <= RST_LENGTH_LIMIT;
		end else if (wr_en) begin
			case (wr_index)
				CFG_HEADER_FIRST:   cfg_q.header_first   <= wr_data;
				CFG_HEADER_SECOND:  cfg_q.header_second  <= wr_data;
				CFG_DATA_TYPE_CODE: cfg_q.data_type_code <= wr_data[1:0];
				CFG_LENGTH_LIMIT:   cfg_q.length_limit   <= wr_data[6:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/cfp_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_parser
// Frame state machine, running checksum and payload store; one byte a step.
// ----------------------------------------------------------------------------
module cfp_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfp_pkg::cfg_t cfg,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	output logic               res_valid,
	output cfp_pkg::result_t   res
);
	import cfp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_HDR2    = 3'd2,
		PH_TYPE    = 3'd3,
		PH_IDENT   = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CHECK   = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [5:0]  left_q, left_d;
	logic [5:0]  idx_q, idx_d;
	logic [7:0]  sum_q, sum_d;
	logic [1:0]  type_q, type_d;
	logic [7:0]  ident_q, ident_d;
	logic [5:0]  len_q, len_d;
	logic [7:0]  store_q [STORE_SLOTS];
	logic [7:0]  store_d [STORE_SLOTS];

	logic [7:0]  sum_add;
	logic [6:0]  limit;
	logic        len_ok;

	assign sum_add = sum_q + rx_byte;
	assign limit   = (cfg.length_limit > LIMIT_CAP) ? LIMIT_CAP : cfg.length_limit;
	assign len_ok  = (rx_byte != 8'd0) && (rx_byte < {1'b0, limit});

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		idx_d     = idx_q;
		sum_d     = sum_q;
		type_d    = type_q;
		ident_d   = ident_q;
		len_d     = len_q;
		store_d   = store_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte == cfg.header_first) begin
					sum_d   = rx_byte;
					phase_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (rx_byte == cfg.header_second) begin
					sum_d   = sum_add;
					phase_d = PH_HDR2;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_HDR2: begin
				if (rx_byte < TYPE_BOUND) begin
					sum_d   = sum_add;
					type_d  = rx_byte[1:0];
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_TYPE: begin
				sum_d   = sum_add;
				ident_d = rx_byte;
				phase_d = PH_IDENT;
			end
			PH_IDENT: begin
				if (len_ok) begin
					sum_d   = sum_add;
					len_d   = rx_byte[5:0];
					left_d  = rx_byte[5:0];
					idx_d   = 6'd0;
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_PAYLOAD: begin
				if (left_q == 6'd0) begin
					phase_d = PH_IDLE;
				end else begin
					sum_d = sum_add;
					if (idx_q[5:3] == 3'd0) begin
						store_d[idx_q[2:0]] = rx_byte;
					end
					idx_d  = idx_q + 6'd1;
					left_d = left_q - 6'd1;
					if (left_q == 6'd1) begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				// The checksum byte itself lands in the slot after a short
				// payload, and the values read the store after that write.
				phase_d = PH_IDLE;
				if (idx_q[5:3] == 3'd0) begin
					store_d[idx_q[2:0]] = rx_byte;
				end
				res_valid          = 1'b1;
				res.frame_class    = type_q;
				res.identifier     = ident_q;
				res.payload_length = len_q;
				if (rx_byte != sum_q) begin
					res.status = ST_CSUM_ERR;
				end else if (type_q == cfg.data_type_code) begin
					res.status             = ST_DATA;
					res.speed_value        = {store_d[1], store_d[0]};
					res.angle_value        = {store_d[3], store_d[2]};
					res.target_angle_value = {store_d[5], store_d[4]};
					res.steer_output_value = {store_d[7], store_d[6]};
				end else begin
					res.status = ST_ACCEPT;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			ident_q <= '0;
			len_q   <= '0;
			for (int i = 0; i < STORE_SLOTS; i++) begin
				store_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
			type_q  <= type_d;
			ident_q <= ident_d;
			len_q   <= len_d;
			store_q <= store_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/cfp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks of the frame parser, bound to its top level.
// ----------------------------------------------------------------------------
module cfp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [3:0]  m_tuser,
	input  wire logic [79:0] m_tdata
);
	import cfp_pkg::*;

	// A result that is not taken stays on the bus unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed or dropped while stalled");

	// Status is one of the three defined codes and the length is nonzero.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] != 2'd3) && (m_tdata[13:8] != 6'd0))
		else $error("bad status or zero length in result");

	// Only a data frame carries values.
	a_values: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != ST_DATA) |-> m_tdata[77:14] == 64'd0)
		else $error("values present on a non-data result");

	// A fresh result must be preceded by a byte transfer on the input side.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a preceding byte transfer");

endmodule

bind checksummed_frame_parser cfp_checker u_cfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);
`default_nettype wire
